### src/tqbr_pkg.sv
package tqbr_pkg;

  localparam int FRAMES    = 16;
  localparam int PAGE_BITS = 32;
  localparam int PIN_BITS  = 8;

  localparam int SLOT_W     = $clog2(FRAMES);
  localparam int LEN_W      = $clog2(FRAMES + 1);
  localparam int SLOT_OUT_W = 4;

  localparam int IN_TDATA_W  = ((PAGE_BITS + 1 + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((SLOT_OUT_W + 3 + PAGE_BITS + 7) / 8) * 8;

  localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};

  localparam logic CMD_FIX   = 1'b0;
  localparam logic CMD_UNFIX = 1'b1;

  typedef enum logic [2:0] {
    ST_HIT_LRU    = 3'd0,
    ST_HIT_FIFO   = 3'd1,
    ST_MISS_FREE  = 3'd2,
    ST_MISS_EVICT = 3'd3,
    ST_ALL_PINNED = 3'd4,
    ST_UNFIX_OK   = 3'd5,
    ST_UNFIX_ERR  = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FETCH,
    S_APPLY
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_UNPIN,
    OP_LRU_TOUCH,
    OP_PROMOTE,
    OP_FILL,
    OP_EVICT_FIFO,
    OP_EVICT_LRU
  } op_t;

endpackage

### src/tqbr_ram.sv
module tqbr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/two_queue_buffer_replacement_core.sv
// Channel  Dir  Words                 tdata / tuser
// s_*      in   fix / unfix request   tdata: page_number, mark_dirty; tuser: cmd
// m_*      out  one result per word   tdata: frame_slot, load, writeback, victim;
//                                     tuser: status
//
// Each request scans the frame slots with one tag memory read per slot
// (single read port), then reads the victim's tag, then applies the result.
// Reset (rst, synchronous) empties both queues and marks all slots free;
// the tag memory is not cleared, since a slot's tag is read only while valid.
// A new request is taken while the last result still waits on m_tready;
// the apply state holds until the output register is free.
module two_queue_buffer_replacement_core
  import tqbr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // [PAGE_BITS-1:0] page_number, [PAGE_BITS] mark_dirty, zero pad above
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // [0] cmd
  input  logic                   s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // [3:0] frame_slot, [4] load_needed, [5] writeback_needed, [6] victim_valid,
  // [PAGE_BITS+6:7] victim_page, zero pad above
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // [2:0] status
  output logic [2:0]             m_tuser
);

  state_t state, state_next;

  // request held for the whole pass
  logic                 req_cmd;
  logic [PAGE_BITS-1:0] req_page;
  logic                 req_dirty;

  // per-slot bookkeeping; rank is the position inside the slot's queue
  logic                valid  [FRAMES];
  logic                in_lru [FRAMES];
  logic                dirty  [FRAMES];
  logic [PIN_BITS-1:0] pin    [FRAMES];
  logic [SLOT_W-1:0]   rank   [FRAMES];
  logic [LEN_W-1:0]    fifo_len;
  logic [LEN_W-1:0]    lru_len;

  // scan
  logic [SLOT_W-1:0] cnt;
  logic [SLOT_W-1:0] rd_slot;
  logic              rd_vld;
  logic              hit_found;
  logic [SLOT_W-1:0] hit_slot;
  logic              free_found;
  logic [SLOT_W-1:0] free_slot;
  logic              fv_found;
  logic [SLOT_W-1:0] fv_slot;
  logic [SLOT_W-1:0] fv_rank;
  logic              lv_found;
  logic [SLOT_W-1:0] lv_slot;
  logic [SLOT_W-1:0] lv_rank;

  // tag memory
  logic                 ram_we;
  logic [SLOT_W-1:0]    ram_raddr;
  logic [PAGE_BITS-1:0] ram_rdata;

  // apply decision
  op_t                  op;
  status_t              ap_status;
  logic [SLOT_W-1:0]    sel;
  logic                 ap_load;
  logic                 ap_wb;
  logic                 ap_vv;
  logic [PAGE_BITS-1:0] ap_vpage;
  logic [SLOT_W-1:0]    victim;
  logic                 commit;

  // output register
  logic                 out_valid;
  status_t              out_status;
  logic [SLOT_W-1:0]    out_slot;
  logic                 out_load;
  logic                 out_wb;
  logic                 out_vv;
  logic [PAGE_BITS-1:0] out_vpage;

  assign victim = fv_found ? fv_slot : lv_slot;
  assign commit = (state == S_APPLY) && (!out_valid || m_tready);

  tqbr_ram #(
    .WIDTH (PAGE_BITS),
    .DEPTH (FRAMES)
  ) u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (sel),
    .wdata (req_page),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // keep the victim's tag on the read port while apply waits for the output
  assign ram_raddr = (state == S_FETCH || state == S_APPLY) ? victim : cnt;
  assign ram_we    = commit && (op == OP_FILL || op == OP_EVICT_FIFO || op == OP_EVICT_LRU);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (s_tvalid) state_next = S_SCAN;
      S_SCAN:  if (cnt == SLOT_W'(FRAMES - 1)) state_next = S_FETCH;
      S_FETCH: state_next = S_APPLY;
      S_APPLY: if (commit) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_tready = 1'b0;
    unique case (state)
      S_IDLE:  s_tready = 1'b1;
      S_SCAN, S_FETCH, S_APPLY: s_tready = 1'b0;
      default: s_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // scan: walk the slots, compare each tag in the cycle after its read,
  // track the lowest free slot and the oldest unpinned slot of each queue
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= (state == S_SCAN);
    end
    rd_slot <= cnt;
    if (s_tvalid && s_tready) begin
      req_cmd    <= s_tuser;
      req_page   <= s_tdata[PAGE_BITS-1:0];
      req_dirty  <= s_tdata[PAGE_BITS];
      cnt        <= '0;
      hit_found  <= 1'b0;
      hit_slot   <= '0;
      free_found <= 1'b0;
      free_slot  <= '0;
      fv_found   <= 1'b0;
      fv_slot    <= '0;
      fv_rank    <= '0;
      lv_found   <= 1'b0;
      lv_slot    <= '0;
      lv_rank    <= '0;
    end else begin
      if (state == S_SCAN) begin
        cnt <= cnt + 1'b1;
        if (!valid[cnt] && !free_found) begin
          free_found <= 1'b1;
          free_slot  <= cnt;
        end
        if (valid[cnt] && pin[cnt] == '0) begin
          if (in_lru[cnt]) begin
            if (!lv_found || rank[cnt] < lv_rank) begin
              lv_found <= 1'b1;
              lv_slot  <= cnt;
              lv_rank  <= rank[cnt];
            end
          end else if (!fv_found || rank[cnt] < fv_rank) begin
            fv_found <= 1'b1;
            fv_slot  <= cnt;
            fv_rank  <= rank[cnt];
          end
        end
      end
      if (rd_vld && valid[rd_slot] && ram_rdata == req_page) begin
        hit_found <= 1'b1;
        hit_slot  <= rd_slot;
      end
    end
  end

  // decide the outcome of the request
  always_comb begin
    op        = OP_NONE;
    ap_status = ST_ALL_PINNED;
    sel       = '0;
    ap_load   = 1'b0;
    ap_wb     = 1'b0;
    ap_vv     = 1'b0;
    ap_vpage  = '0;
    if (req_cmd == CMD_UNFIX) begin
      ap_status = ST_UNFIX_ERR;
      if (hit_found) begin
        sel = hit_slot;
        if (pin[hit_slot] != '0) begin
          ap_status = ST_UNFIX_OK;
          op        = OP_UNPIN;
        end
      end
    end else if (hit_found) begin
      sel = hit_slot;
      if (pin[hit_slot] == PIN_MAX) begin
        ap_status = ST_ALL_PINNED;
      end else if (in_lru[hit_slot]) begin
        ap_status = ST_HIT_LRU;
        op        = OP_LRU_TOUCH;
      end else begin
        ap_status = ST_HIT_FIFO;
        op        = OP_PROMOTE;
      end
    end else if (free_found) begin
      sel       = free_slot;
      ap_status = ST_MISS_FREE;
      op        = OP_FILL;
      ap_load   = 1'b1;
    end else if (fv_found || lv_found) begin
      sel       = victim;
      ap_status = ST_MISS_EVICT;
      op        = fv_found ? OP_EVICT_FIFO : OP_EVICT_LRU;
      ap_load   = 1'b1;
      ap_vv     = 1'b1;
      ap_wb     = dirty[victim];
      ap_vpage  = ram_rdata;
    end
  end

  // apply: unpin a slot, or close the gap left in a queue and place the slot at a tail
  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_len <= '0;
      lru_len  <= '0;
      for (int i = 0; i < FRAMES; i++) begin
        valid[i]  <= 1'b0;
        in_lru[i] <= 1'b0;
        dirty[i]  <= 1'b0;
        pin[i]    <= '0;
      end
    end else if (commit) begin
      unique case (op)
        OP_PROMOTE: begin
          fifo_len <= fifo_len - 1'b1;
          lru_len  <= lru_len + 1'b1;
        end
        OP_FILL: fifo_len <= fifo_len + 1'b1;
        OP_NONE, OP_UNPIN, OP_LRU_TOUCH, OP_EVICT_FIFO, OP_EVICT_LRU: ;
        default: ;
      endcase
      for (int i = 0; i < FRAMES; i++) begin
        unique case (op)
          OP_UNPIN: begin
            if (SLOT_W'(i) == sel) begin
              pin[i]   <= pin[i] - 1'b1;
              dirty[i] <= dirty[i] | req_dirty;
            end
          end
          OP_LRU_TOUCH, OP_EVICT_LRU: begin
            if (valid[i] && in_lru[i] && rank[i] > rank[sel]) begin
              rank[i] <= rank[i] - 1'b1;
            end
            if (SLOT_W'(i) == sel) begin
              rank[i] <= SLOT_W'(lru_len - 1'b1);
              if (op == OP_LRU_TOUCH) begin
                pin[i] <= pin[i] + 1'b1;
              end else begin
                pin[i]   <= PIN_BITS'(1);
                dirty[i] <= 1'b0;
              end
            end
          end
          OP_PROMOTE: begin
            if (valid[i] && !in_lru[i] && rank[i] > rank[sel]) begin
              rank[i] <= rank[i] - 1'b1;
            end
            if (SLOT_W'(i) == sel) begin
              rank[i]   <= SLOT_W'(lru_len);
              in_lru[i] <= 1'b1;
              pin[i]    <= pin[i] + 1'b1;
            end
          end
          OP_FILL: begin
            if (SLOT_W'(i) == sel) begin
              valid[i]  <= 1'b1;
              in_lru[i] <= 1'b0;
              dirty[i]  <= 1'b0;
              pin[i]    <= PIN_BITS'(1);
              rank[i]   <= SLOT_W'(fifo_len);
            end
          end
          OP_EVICT_FIFO: begin
            if (valid[i] && !in_lru[i] && rank[i] > rank[sel]) begin
              rank[i] <= rank[i] - 1'b1;
            end
            if (SLOT_W'(i) == sel) begin
              rank[i]  <= SLOT_W'(fifo_len - 1'b1);
              pin[i]   <= PIN_BITS'(1);
              dirty[i] <= 1'b0;
            end
          end
          OP_NONE: ;
          default: ;
        endcase
      end
    end
  end

  // output register: load on commit, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
    if (commit) begin
      out_status <= ap_status;
      out_slot   <= sel;
      out_load   <= ap_load;
      out_wb     <= ap_wb;
      out_vv     <= ap_vv;
      out_vpage  <= ap_vpage;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tdata  = OUT_TDATA_W'({out_vpage, out_vv, out_wb, out_load, SLOT_OUT_W'(out_slot)});

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    ((LEN_W + 1)'(fifo_len) + (LEN_W + 1)'(lru_len)) <= (LEN_W + 1)'(FRAMES))
    else $error("queue lengths exceed frame count");

  a_fill_free: assert property (@(posedge clk) disable iff (rst)
    (commit && op == OP_FILL) |-> !valid[sel])
    else $error("fill into an occupied slot");

  a_commit_out: assert property (@(posedge clk) disable iff (rst)
    commit |=> (m_tvalid && m_tuser == $past(ap_status)))
    else $error("committed result not presented");

endmodule
